// ===== rtl/core/qrs_pkg.sv =====
// qrs_pkg: shared types, widths and codes for the quadratic root solver
// used by qrs_sqrt_pipe, qrs_div_pipe and quadratic_root_solver_unit
// no dependencies
`timescale 1ns / 1ps

package qrs_pkg;

	// field widths
	localparam int COEF_W     = 32;
	localparam int TOL_W      = 16;
	localparam int MAG_W      = 32;
	localparam int PROD_W     = 2 * MAG_W;
	localparam int DISC_W     = PROD_W + 2;
	localparam int ROOT_W     = DISC_W / 2 + 1;
	localparam int SQRT_STEPS = ROOT_W;
	localparam int BASE_W     = COEF_W + 1;
	localparam int NUM_W      = ROOT_W + 2;
	localparam int DEN_W      = MAG_W + 2;
	localparam int FRAC_SH    = 17;
	localparam int DIVD_W     = NUM_W - 1 + FRAC_SH + 1;
	localparam int DIVS_W     = DEN_W + 1;

	// root count codes
	localparam logic [1:0] CNT_NONE = 2'd0;
	localparam logic [1:0] CNT_ONE  = 2'd1;
	localparam logic [1:0] CNT_TWO  = 2'd2;
	localparam logic [1:0] CNT_INF  = 2'd3;

	// saturation limits
	localparam logic [COEF_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
	localparam logic [COEF_W-1:0] NEG_LIMIT = 32'h8000_0000;

	typedef struct packed {
		logic signed [COEF_W-1:0] coef_a;
		logic signed [COEF_W-1:0] coef_b;
		logic signed [COEF_W-1:0] coef_c;
	} in_word_t;

	typedef struct packed {
		logic [1:0]               root_count;
		logic signed [COEF_W-1:0] root_one;
		logic signed [COEF_W-1:0] root_two;
		logic                     overflow;
	} out_word_t;

	// sideband riding along the square root pipe
	typedef struct packed {
		logic [1:0]               count;
		logic                     den_neg;
		logic signed [BASE_W-1:0] num_base;
		logic [DEN_W-1:0]         den_mag;
	} sqrt_tag_t;

	// magnitude of a signed coefficient
	function automatic logic [MAG_W-1:0] coef_mag(input logic signed [COEF_W-1:0] v);
		logic [MAG_W-1:0] u;
		u = v;
		return u[MAG_W-1] ? (~u + 32'd1) : u;
	endfunction

endpackage

// ===== rtl/core/qrs_sqrt_pipe.sv =====
// qrs_sqrt_pipe: floor integer square root, one result bit per pipeline stage
// depends on qrs_pkg
`timescale 1ns / 1ps

module qrs_sqrt_pipe #(
	parameter int TAG_W = $bits(qrs_pkg::sqrt_tag_t)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [qrs_pkg::DISC_W-1:0]  radicand,
	input  logic [TAG_W-1:0]            tag_in,
	output logic                        out_valid,
	output logic [qrs_pkg::ROOT_W-1:0]  root,
	output logic [TAG_W-1:0]            tag_out
);
	import qrs_pkg::*;

	localparam int RAD_W = 2 * SQRT_STEPS;
	localparam int REM_W = ROOT_W + 2;

	logic               vld_s  [SQRT_STEPS+1];
	logic [REM_W-1:0]   rem_s  [SQRT_STEPS+1];
	logic [ROOT_W-1:0]  root_s [SQRT_STEPS+1];
	logic [RAD_W-1:0]   rad_s  [SQRT_STEPS+1];
	logic [TAG_W-1:0]   tag_s  [SQRT_STEPS+1];

	// entry stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= '0;
			root_s[0] <= '0;
			rad_s[0]  <= RAD_W'(radicand);
			tag_s[0]  <= tag_in;
		end
	end

	// one root bit per stage
	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		logic [REM_W+1:0] cat;
		logic [REM_W+1:0] trial;
		logic             ge;

		always_comb begin
			cat   = {rem_s[k], rad_s[k][RAD_W-1 -: 2]};
			trial = {2'b00, root_s[k], 2'b01};
			ge    = (cat >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? REM_W'(cat - trial) : REM_W'(cat);
				root_s[k+1] <= {root_s[k][ROOT_W-2:0], ge};
				rad_s[k+1]  <= {rad_s[k][RAD_W-3:0], 2'b00};
				tag_s[k+1]  <= tag_s[k];
			end
		end
	end

	assign out_valid = vld_s[SQRT_STEPS];
	assign root      = root_s[SQRT_STEPS];
	assign tag_out   = tag_s[SQRT_STEPS];

endmodule

// ===== rtl/core/qrs_div_pipe.sv =====
// qrs_div_pipe: rounded fixed point quotient round(num * 2^16 / den), saturated
// restoring long division, one quotient bit per stage; depends on qrs_pkg
`timescale 1ns / 1ps

module qrs_div_pipe #(
	parameter int TAG_W = 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic signed [qrs_pkg::NUM_W-1:0]  num,
	input  logic [qrs_pkg::DEN_W-1:0]         den_mag,
	input  logic                              den_neg,
	input  logic [TAG_W-1:0]                  tag_in,
	output logic                              out_valid,
	output logic [qrs_pkg::COEF_W-1:0]        quo,
	output logic                              ovf,
	output logic [TAG_W-1:0]                  tag_out
);
	import qrs_pkg::*;

	localparam int NM_W  = NUM_W - 1;
	localparam int STEPS = DIVD_W;

	// magnitude stage
	logic              vld_p1;
	logic [NM_W-1:0]   nm_p1;
	logic              neg_p1;
	logic [DEN_W-1:0]  den_p1;
	logic [TAG_W-1:0]  tag_p1;
	logic [NUM_W-1:0]  num_u;

	assign num_u = num;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p1 <= 1'b0;
		end else if (en) begin
			vld_p1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nm_p1  <= num_u[NUM_W-1] ? NM_W'(~num_u + 1'b1) : NM_W'(num_u);
			neg_p1 <= num_u[NUM_W-1] ^ den_neg;
			den_p1 <= den_mag;
			tag_p1 <= tag_in;
		end
	end

	// dividend and divisor set up for rounding
	logic               vld_s  [STEPS+1];
	logic [DIVD_W-1:0]  dvd_s  [STEPS+1];
	logic [DIVS_W-1:0]  dvs_s  [STEPS+1];
	logic [DIVS_W-1:0]  rem_s  [STEPS+1];
	logic [DIVD_W-1:0]  quo_s  [STEPS+1];
	logic               neg_s  [STEPS+1];
	logic [TAG_W-1:0]   tag_s  [STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_p1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvd_s[0] <= DIVD_W'({nm_p1, {FRAC_SH{1'b0}}}) + DIVD_W'(den_p1);
			dvs_s[0] <= {den_p1, 1'b0};
			rem_s[0] <= '0;
			quo_s[0] <= '0;
			neg_s[0] <= neg_p1;
			tag_s[0] <= tag_p1;
		end
	end

	// one quotient bit per stage
	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic [DIVS_W:0] cat;
		logic            ge;

		always_comb begin
			cat = {rem_s[k], dvd_s[k][DIVD_W-1]};
			ge  = (cat >= {1'b0, dvs_s[k]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? DIVS_W'(cat - {1'b0, dvs_s[k]}) : DIVS_W'(cat);
				quo_s[k+1] <= {quo_s[k][DIVD_W-2:0], ge};
				dvd_s[k+1] <= {dvd_s[k][DIVD_W-2:0], 1'b0};
				dvs_s[k+1] <= dvs_s[k];
				neg_s[k+1] <= neg_s[k];
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	// sign and saturation
	logic [DIVD_W-1:0] q_fin;
	logic              neg_fin;
	logic [COEF_W-1:0] sat_val;
	logic              sat_ovf;

	assign q_fin   = quo_s[STEPS];
	assign neg_fin = neg_s[STEPS];

	always_comb begin
		if (!neg_fin) begin
			sat_ovf = (q_fin > DIVD_W'(POS_LIMIT));
			sat_val = sat_ovf ? POS_LIMIT : q_fin[COEF_W-1:0];
		end else begin
			sat_ovf = (q_fin > DIVD_W'(NEG_LIMIT));
			sat_val = sat_ovf ? NEG_LIMIT : (~q_fin[COEF_W-1:0] + 32'd1);
		end
	end

	logic              vld_q;
	logic [COEF_W-1:0] quo_q;
	logic              ovf_q;
	logic [TAG_W-1:0]  tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_q <= sat_val;
			ovf_q <= sat_ovf;
			tag_q <= tag_s[STEPS];
		end
	end

	assign out_valid = vld_q;
	assign quo       = quo_q;
	assign ovf       = ovf_q;
	assign tag_out   = tag_q;

endmodule

// ===== rtl/core/quadratic_root_solver_unit.sv =====
// out_valid follows the accepting edge through 97 register stages (4 front, 35 square root,
// 1 numerator, 56 divider, 1 output); throughput: one word per cycle while the pipeline is not stalled
// a two-word output register (output plus skid) stalls the whole pipeline only when full
// reset: arst_n clears all valid bits, the output and skid full flags and tol_q to 0
// quadratic_root_solver_unit: top level; depends on qrs_pkg, qrs_sqrt_pipe, qrs_div_pipe
`timescale 1ns / 1ps

module quadratic_root_solver_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  qrs_pkg::in_word_t          in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output qrs_pkg::out_word_t         out_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [qrs_pkg::TOL_W-1:0]  cfg_data
);
	import qrs_pkg::*;

	logic en;

	// tolerance register
	logic [TOL_W-1:0] tol_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			tol_q <= cfg_data;
		end
	end

	// stage 1: input capture
	logic     valid_s1;
	in_word_t coef_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coef_s1 <= in_data;
		end
	end

	// stage 2: magnitudes and near-zero tests
	logic [TOL_W-1:0] coef_thr;
	logic [MAG_W-1:0] mag_a, mag_b, mag_c;

	assign coef_thr = (tol_q == '0) ? TOL_W'(1) : tol_q;
	assign mag_a    = coef_mag(coef_s1.coef_a);
	assign mag_b    = coef_mag(coef_s1.coef_b);
	assign mag_c    = coef_mag(coef_s1.coef_c);

	logic             valid_s2;
	logic [MAG_W-1:0] maga_s2, magb_s2, magc_s2;
	logic             nega_s2, negb_s2, negc_s2;
	logic             az_s2, bz_s2, cz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			maga_s2 <= mag_a;
			magb_s2 <= mag_b;
			magc_s2 <= mag_c;
			nega_s2 <= coef_s1.coef_a[COEF_W-1];
			negb_s2 <= coef_s1.coef_b[COEF_W-1];
			negc_s2 <= coef_s1.coef_c[COEF_W-1];
			az_s2   <= (mag_a < MAG_W'(coef_thr));
			bz_s2   <= (mag_b < MAG_W'(coef_thr));
			cz_s2   <= (mag_c < MAG_W'(coef_thr));
		end
	end

	// stage 3: b*b and a*c
	logic              valid_s3;
	logic [PROD_W-1:0] bb_s3, ac_s3;
	logic [MAG_W-1:0]  maga_s3, magb_s3, magc_s3;
	logic              nega_s3, negb_s3, negc_s3;
	logic              az_s3, bz_s3, cz_s3, acn_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bb_s3   <= PROD_W'(magb_s2) * PROD_W'(magb_s2);
			ac_s3   <= PROD_W'(maga_s2) * PROD_W'(magc_s2);
			maga_s3 <= maga_s2;
			magb_s3 <= magb_s2;
			magc_s3 <= magc_s2;
			nega_s3 <= nega_s2;
			negb_s3 <= negb_s2;
			negc_s3 <= negc_s2;
			az_s3   <= az_s2;
			bz_s3   <= bz_s2;
			cz_s3   <= cz_s2;
			acn_s3  <= (nega_s2 ^ negc_s2) && (maga_s2 != '0) && (magc_s2 != '0);
		end
	end

	// stage 4: discriminant magnitude and sign
	logic [DISC_W-1:0] bb_w, fac_w, d_sum, d_pos, d_neg;
	logic              fac_le;

	always_comb begin
		bb_w   = DISC_W'(bb_s3);
		fac_w  = {ac_s3, 2'b00};
		d_sum  = bb_w + fac_w;
		d_pos  = bb_w - fac_w;
		d_neg  = fac_w - bb_w;
		fac_le = (fac_w <= bb_w);
	end

	logic              valid_s4;
	logic [DISC_W-1:0] dmag_s4;
	logic              dneg_s4;
	logic [MAG_W-1:0]  maga_s4, magb_s4, magc_s4;
	logic              nega_s4, negb_s4, negc_s4;
	logic              az_s4, bz_s4, cz_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dmag_s4 <= acn_s3 ? d_sum : (fac_le ? d_pos : d_neg);
			dneg_s4 <= !acn_s3 && !fac_le;
			maga_s4 <= maga_s3;
			magb_s4 <= magb_s3;
			magc_s4 <= magc_s3;
			nega_s4 <= nega_s3;
			negb_s4 <= negb_s3;
			negc_s4 <= negc_s3;
			az_s4   <= az_s3;
			bz_s4   <= bz_s3;
			cz_s4   <= cz_s3;
		end
	end

	// case selection: linear, infinite, double root, two roots or none
	logic [COEF_W-1:0] disc_thr;
	logic              dsmall;
	logic [BASE_W-1:0] neg_b_base, neg_c_base;
	sqrt_tag_t         cls_tag;
	logic [DISC_W-1:0] cls_rad;

	assign disc_thr   = (tol_q == '0) ? COEF_W'(1) : {tol_q, 16'h0000};
	assign dsmall     = (dmag_s4 < DISC_W'(disc_thr));
	assign neg_b_base = negb_s4 ? {1'b0, magb_s4} : (~{1'b0, magb_s4} + 1'b1);
	assign neg_c_base = negc_s4 ? {1'b0, magc_s4} : (~{1'b0, magc_s4} + 1'b1);

	always_comb begin
		cls_tag.count    = CNT_NONE;
		cls_tag.den_neg  = 1'b0;
		cls_tag.num_base = '0;
		cls_tag.den_mag  = DEN_W'(1);
		cls_rad          = '0;
		if (az_s4) begin
			if (!bz_s4) begin
				cls_tag.count    = CNT_ONE;
				cls_tag.den_neg  = negb_s4;
				cls_tag.num_base = neg_c_base;
				cls_tag.den_mag  = DEN_W'(magb_s4);
			end else if (cz_s4) begin
				cls_tag.count = CNT_INF;
			end
		end else if (dsmall) begin
			cls_tag.count    = CNT_ONE;
			cls_tag.den_neg  = nega_s4;
			cls_tag.num_base = neg_b_base;
			cls_tag.den_mag  = DEN_W'({maga_s4, 1'b0});
		end else if (!dneg_s4) begin
			cls_tag.count    = CNT_TWO;
			cls_tag.den_neg  = nega_s4;
			cls_tag.num_base = neg_b_base;
			cls_tag.den_mag  = DEN_W'({maga_s4, 1'b0});
			cls_rad          = dmag_s4;
		end
	end

	// square root of the discriminant
	logic              sq_valid;
	logic [ROOT_W-1:0] sq_root;
	sqrt_tag_t         sq_tag;

	qrs_sqrt_pipe #(
		.TAG_W($bits(sqrt_tag_t))
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s4),
		.radicand (cls_rad),
		.tag_in   (cls_tag),
		.out_valid(sq_valid),
		.root     (sq_root),
		.tag_out  (sq_tag)
	);

	// numerators -b + s and -b - s (-c for the linear case)
	logic                    valid_s6;
	logic signed [NUM_W-1:0] n1_s6, n2_s6;
	logic [DEN_W-1:0]        den_s6;
	logic                    dneg_s6;
	logic [1:0]              cnt_s6;
	logic [NUM_W-1:0]        base_w, root_w;

	assign base_w = NUM_W'(sq_tag.num_base);
	assign root_w = NUM_W'(sq_root);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s6 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n1_s6   <= base_w + root_w;
			n2_s6   <= base_w - root_w;
			den_s6  <= sq_tag.den_mag;
			dneg_s6 <= sq_tag.den_neg;
			cnt_s6  <= sq_tag.count;
		end
	end

	// the two quotients
	logic              d1_valid, d1_ovf, d2_ovf;
	logic [COEF_W-1:0] d1_quo, d2_quo;
	logic [1:0]        d1_cnt;
	logic              d2_two;

	qrs_div_pipe #(
		.TAG_W(2)
	) u_div_one (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s6),
		.num      (n1_s6),
		.den_mag  (den_s6),
		.den_neg  (dneg_s6),
		.tag_in   (cnt_s6),
		.out_valid(d1_valid),
		.quo      (d1_quo),
		.ovf      (d1_ovf),
		.tag_out  (d1_cnt)
	);

	qrs_div_pipe #(
		.TAG_W(1)
	) u_div_two (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s6),
		.num      (n2_s6),
		.den_mag  (den_s6),
		.den_neg  (dneg_s6),
		.tag_in   (cnt_s6 == CNT_TWO),
		.out_valid(),
		.quo      (d2_quo),
		.ovf      (d2_ovf),
		.tag_out  (d2_two)
	);

	// result word assembly
	out_word_t res;
	logic      has_one;

	always_comb begin
		has_one        = (d1_cnt == CNT_ONE) || (d1_cnt == CNT_TWO);
		res.root_count = d1_cnt;
		res.root_one   = has_one ? d1_quo : '0;
		res.root_two   = d2_two ? d2_quo : '0;
		res.overflow   = (has_one && d1_ovf) || (d2_two && d2_ovf);
	end

	// output register with skid word
	out_word_t out_q, skid_q;
	logic      out_full_q, skid_full_q;
	logic      push, pop;

	assign en       = !skid_full_q;
	assign in_ready = en;
	assign push     = en && d1_valid;
	assign pop      = out_full_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q  <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (pop) begin
			if (skid_full_q) begin
				skid_full_q <= 1'b0;
			end else begin
				out_full_q <= push;
			end
		end else if (push) begin
			if (out_full_q) begin
				skid_full_q <= 1'b1;
			end else begin
				out_full_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_full_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= res;
			end
		end else if (push) begin
			if (out_full_q) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign out_valid = out_full_q;
	assign out_data  = out_q;

endmodule

// ===== test/quadratic_root_solver_unit_tb.sv =====
// quadratic_root_solver_unit_tb: self-checking bench for the quadratic root solver
// checks each result word against a bit-exact predictor or a directed expectation, under random idling and stalls
// depends on qrs_pkg and quadratic_root_solver_unit
`timescale 1ns / 1ps

module quadratic_root_solver_unit_tb;
	import qrs_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN       = 120;
	localparam int LIMIT       = 300000;
	localparam int PHASE_WORDS = 480;

	// one directed row: stimulus, and the expected word where it is obvious
	typedef struct packed {
		in_word_t  w;
		logic      known;
		out_word_t e;
	} row_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_data;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [TOL_W-1:0] cfg_data;

	out_word_t  pending_roots[$];
	logic [15:0] tol_now;
	int errors;
	int words_in;
	int words_out;
	int cycles;
	logic quiet;
	logic hold_req;
	logic hold_off;
	logic drained;

	quadratic_root_solver_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// round(num * 2^16 / den) with ties away from zero, saturated; bit 32 is overflow
	function automatic logic [32:0] q16_quotient(logic signed [39:0] num, logic [35:0] den_mag,
			logic den_neg);
		logic [39:0] nm;
		logic [79:0] q;
		logic neg;
		nm = num < 0 ? -num : num;
		neg = (num < 0) != den_neg;
		q = ({40'd0, nm} << 17) + den_mag;
		q = q / ({44'd0, den_mag} << 1);
		if (!neg) begin
			if (q > 80'h7FFF_FFFF) return {1'b1, POS_LIMIT};
			return {1'b0, q[31:0]};
		end
		if (q > 80'h8000_0000) return {1'b1, NEG_LIMIT};
		return {1'b0, -q[31:0]};
	endfunction

	// real roots of a*x^2 + b*x + c for one coefficient word
	function automatic out_word_t solve_roots(in_word_t w, logic [15:0] tol);
		longint la, lb, lc, ma, mb, mc, cthr;
		logic signed [69:0] sa, sb, sc, disc;
		logic [69:0] dmag, dthr, t;
		logic [33:0] s;
		logic [32:0] q1, q2;
		logic signed [39:0] base;
		out_word_t r;
		la = w.coef_a; lb = w.coef_b; lc = w.coef_c;
		ma = la < 0 ? -la : la;
		mb = lb < 0 ? -lb : lb;
		mc = lc < 0 ? -lc : lc;
		cthr = tol == 0 ? 1 : longint'(tol);
		r = '0;
		if (ma < cthr) begin
			if (mb >= cthr) begin
				q1 = q16_quotient(40'(-lc), 36'(mb), lb < 0);
				r.root_count = CNT_ONE;
				r.root_one = q1[31:0];
				r.overflow = q1[32];
			end else if (mc < cthr) r.root_count = CNT_INF;
			else r.root_count = CNT_NONE;
			return r;
		end
		sa = la; sb = lb; sc = lc;
		disc = sb * sb - 4 * sa * sc;
		dmag = disc < 0 ? -disc : disc;
		dthr = tol == 0 ? 70'd1 : (70'(tol) << 16);
		if (dmag < dthr) begin
			q1 = q16_quotient(40'(-lb), 36'(ma) << 1, la < 0);
			r.root_count = CNT_ONE;
			r.root_one = q1[31:0];
			r.overflow = q1[32];
		end else if (disc < 0) r.root_count = CNT_NONE;
		else begin
			s = '0;
			for (int k = 33; k >= 0; k--) begin
				t = 70'(s | (34'd1 << k));
				if (t * t <= dmag) s = t[33:0];
			end
			base = 40'(-lb);
			q1 = q16_quotient(base + $signed({6'd0, s}), 36'(ma) << 1, la < 0);
			q2 = q16_quotient(base - $signed({6'd0, s}), 36'(ma) << 1, la < 0);
			r.root_count = CNT_TWO;
			r.root_one = q1[31:0];
			r.root_two = q2[31:0];
			r.overflow = q1[32] | q2[32];
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("mismatch at word %0d: %s got %0h expected %0h", words_out, what, got, want);
	endtask

	// one word through the input handshake, expectation queued on acceptance
	task automatic send_word(in_word_t w, logic known, out_word_t e);
		while (!quiet && $urandom_range(99) < 9) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = w;
		do @(posedge clk); while (!in_ready);
		pending_roots.push_back(known ? e : solve_roots(w, tol_now));
		words_in++;
		@(negedge clk);
	endtask

	// tolerance write, only with the pipe empty
	task automatic write_tol(logic [15:0] v);
		in_valid = 1'b0;
		wait (pending_roots.size() == 0);
		repeat (DRAIN) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		tol_now = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// random coefficient word, shaped toward each branch
	function automatic in_word_t pick_word(logic [15:0] tol);
		in_word_t w;
		int k, r1, r2;
		w.coef_a = $urandom; w.coef_b = $urandom; w.coef_c = $urandom;
		case ($urandom_range(5))
			0: ;
			1: begin
				// integer roots from a small lead coefficient
				k = $urandom_range(1, 8) * ($urandom_range(1) ? 1 : -1);
				r1 = $urandom_range(0, 40) - 20; r2 = $urandom_range(0, 40) - 20;
				w.coef_a = k <<< 16;
				w.coef_b = (-k * (r1 + r2)) <<< 16;
				w.coef_c = (k * r1 * r2) <<< 16;
			end
			2: begin
				// lead coefficient near the zero threshold
				w.coef_a = $urandom_range(tol + 1) * ($urandom_range(1) ? 1 : -1);
				if ($urandom_range(1)) w.coef_b = $urandom_range(tol + 1);
				if ($urandom_range(1)) w.coef_c = $urandom_range(tol + 1);
			end
			3: begin
				// small fractional coefficients
				w.coef_a = $signed(20'($urandom));
				w.coef_b = $signed(22'($urandom));
				w.coef_c = $signed(20'($urandom));
			end
			4: begin
				// perfect square, discriminant at or near zero
				k = $urandom_range(1, 300);
				r1 = $urandom_range(0, 600) - 300;
				w.coef_a = k;
				w.coef_b = -2 * k * r1;
				w.coef_c = k * r1 * r1 + $urandom_range(2) - 1;
			end
			default: begin
				w.coef_a = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
				w.coef_b = $urandom_range(3);
			end
		endcase
		return w;
	endfunction

	// result checker
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_roots.size() == 0) begin
				errors++;
				$display("unexpected result word %0d", words_out);
			end else begin
				want = pending_roots.pop_front();
				if (out_data.root_count != want.root_count)
					report_mismatch("root_count", out_data.root_count, want.root_count);
				if (out_data.root_one != want.root_one)
					report_mismatch("root_one", out_data.root_one, want.root_one);
				if (out_data.root_two != want.root_two)
					report_mismatch("root_two", out_data.root_two, want.root_two);
				if (out_data.overflow != want.overflow)
					report_mismatch("overflow", out_data.overflow, want.overflow);
			end
			words_out++;
		end
	end

	// receiver with random stalls and a forced hold-off
	always @(negedge clk) begin
		out_ready = arst_n && !hold_off && (quiet || $urandom_range(99) >= 9);
	end

	initial begin
		hold_off = 1'b0;
		wait (hold_req);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_off = 1'b0;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("** quadratic_root_solver_unit: FAILED **");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		row_t dir_rows[13];
		logic [15:0] tols[4];
		out_word_t none;
		none = '0;
		dir_rows = '{
			'{'{32'sd0, 32'sd0, 32'sd0}, 1'b1, '{CNT_INF, 32'sd0, 32'sd0, 1'b0}},
			'{'{32'sd0, 32'sd0, 32'sd1}, 1'b1, '{CNT_NONE, 32'sd0, 32'sd0, 1'b0}},
			'{'{32'sd0, 32'sh1_0000, -32'sh2_0000}, 1'b1,
				'{CNT_ONE, 32'sh2_0000, 32'sd0, 1'b0}},
			'{'{32'sh1_0000, 32'sd0, -32'sh4_0000}, 1'b1,
				'{CNT_TWO, 32'sh2_0000, -32'sh2_0000, 1'b0}},
			'{'{32'sh1_0000, 32'sd0, 32'sh1_0000}, 1'b1,
				'{CNT_NONE, 32'sd0, 32'sd0, 1'b0}},
			'{'{32'sh1_0000, -32'sh2_0000, 32'sh1_0000}, 1'b1,
				'{CNT_ONE, 32'sh1_0000, 32'sd0, 1'b0}},
			'{'{32'sd0, 32'sd1, -32'sh4000_0000}, 1'b1, '{CNT_ONE, POS_LIMIT, 32'sd0, 1'b1}},
			'{'{32'sd0, 32'sd1, 32'sh4000_0000}, 1'b1, '{CNT_ONE, NEG_LIMIT, 32'sd0, 1'b1}},
			'{'{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000}, 1'b0, none},
			'{'{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF}, 1'b0, none},
			'{'{32'sd1, 32'sh8000_0000, 32'sd0}, 1'b0, none},
			'{'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}, 1'b0, none},
			'{'{-32'sd1, 32'sh7FFF_FFFF, -32'sd1}, 1'b0, none}
		};
		tols = '{16'hFFFF, 16'd1, 16'd0, 16'h0000};
		tols[3] = $urandom;
		errors = 0; words_in = 0; words_out = 0; cycles = 0;
		quiet = 1'b0; hold_req = 1'b0; tol_now = '0;
		arst_n = 1'b0;
		in_valid = 1'b0; in_data = '0;
		cfg_valid = 1'b0; cfg_data = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed rows at reset tolerance
		foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].known, dir_rows[i].e);

		// random phases over several tolerance settings
		for (int p = 0; p < 4; p++) begin
			write_tol(tols[p]);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				quiet = (p == 1 && n >= 100 && n < 300);
				if (p == 2 && n == 50) hold_req = 1'b1;
				send_word(pick_word(tol_now), 1'b0, none);
			end
		end
		quiet = 1'b0;
		in_valid = 1'b0;

		wait (pending_roots.size() == 0);
		repeat (DRAIN) @(negedge clk);
		$display("run covered %0d coefficient words over five tolerance settings,", words_in);
		$display("with %0d result words checked under random stalls and one long hold-off",
			words_out);
		if (errors == 0) begin
			$display("** quadratic_root_solver_unit: PASSED **");
		end else begin
			$display("** quadratic_root_solver_unit: FAILED **");
		end
		$finish;
	end

endmodule
